FILE: rtl/tcpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpc_pkg
// Types and codes shared by the TCP client connection state machine.
// ----------------------------------------------------------------------------
package tcpc_pkg;

    localparam int SEQ_W     = 32;
    localparam int LEN_W     = 16;
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 3;

    typedef enum logic [1:0] {
        CMD_CONNECT = 2'd0,
        CMD_CLOSE   = 2'd1,
        CMD_SEND    = 2'd2,
        CMD_SEGMENT = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PH_CLOSED    = 3'd0,
        PH_SYN_SENT  = 3'd1,
        PH_ESTAB     = 3'd2,
        PH_FIN_WAIT1 = 3'd3,
        PH_FIN_WAIT2 = 3'd4,
        PH_CLOSING   = 3'd5,
        PH_TIME_WAIT = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        TX_NONE   = 3'd0,
        TX_SYN    = 3'd1,
        TX_FIN    = 3'd2,
        TX_DATA   = 3'd3,
        TX_ACK    = 3'd4,
        TX_FINACK = 3'd5
    } tx_kind_t;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_CONNECTED = 2'd1,
        EV_MESSAGE   = 2'd2,
        EV_CLOSED    = 2'd3
    } event_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [SEQ_W-1:0] rx_seq;
        logic [LEN_W-1:0] length;
        logic             rx_syn;
        logic             rx_ack;
        logic             rx_fin;
    } item_t;

    typedef struct packed {
        phase_t           phase;
        logic [SEQ_W-1:0] send_seq;
        logic [SEQ_W-1:0] ack_number;
    } ctx_t;

    typedef struct packed {
        tx_kind_t         tx_kind;
        logic [SEQ_W-1:0] tx_seq;
        logic [SEQ_W-1:0] tx_ack_num;
        phase_t           conn_state;
        event_t           event_res;
        logic             protocol_error;
    } result_t;

endpackage

FILE: rtl/tcp_client_connection_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_client_connection_fsm
// Active-open TCP connection header logic: phase, send sequence and
// acknowledge number, one result per request.
// ----------------------------------------------------------------------------
//  Channel  | Ports                          | Contents
//  ---------+--------------------------------+-------------------------------
//  request  | s_tvalid s_tready s_tdata/user | command and segment header
//  result   | m_tvalid m_tready m_tdata/user | segment to send, phase, event
//  config   | cfg_wr_en cfg_wr_data          | initial send sequence number
//
//  One request per cycle sustained while the result side is ready; a stalled
//  result holds the request. A taken request loads the input register, which
//  then feeds the result register. The single-pass context update with its
//  32-bit sequence adder sets this rate.
//  Reset clears the phase, the sequence and acknowledge numbers and both
//  valid flags. A stalled result holds the input stage; s_tready stays high
//  while the input stage is empty or moving.
// ----------------------------------------------------------------------------
module tcp_client_connection_fsm (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tcpc_pkg::SEQ_W-1:0]      cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] rx_seq, [47:32] length, [48] rx_syn, [49] rx_ack, [50] rx_fin
    input  logic [tcpc_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] cmd
    input  logic [tcpc_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] tx_seq, [63:32] tx_ack_num, [66:64] conn_state,
    // [68:67] event_res, [69] protocol_error
    output logic [tcpc_pkg::M_TDATA_W-1:0]  m_tdata,
    // [2:0] tx_kind
    output logic [tcpc_pkg::M_TUSER_W-1:0]  m_tuser
);

    tcpc_pkg::item_t   item_reg;
    logic              in_valid_reg;
    tcpc_pkg::ctx_t    ctx_reg;
    tcpc_pkg::ctx_t    ctx_next;
    tcpc_pkg::result_t res_next;
    tcpc_pkg::result_t res_reg;
    logic              out_valid_reg;
    logic              advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.cmd    <= tcpc_pkg::cmd_t'(s_tuser[1:0]);
            item_reg.rx_seq <= s_tdata[31:0];
            item_reg.length <= s_tdata[47:32];
            item_reg.rx_syn <= s_tdata[48];
            item_reg.rx_ack <= s_tdata[49];
            item_reg.rx_fin <= s_tdata[50];
        end
    end

    tcpc_step u_step (
        .item     (item_reg),
        .ctx      (ctx_reg),
        .ctx_next (ctx_next),
        .res      (res_next)
    );

    // A configuration write seeds the send sequence
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg.phase      <= tcpc_pkg::PH_CLOSED;
            ctx_reg.send_seq   <= '0;
            ctx_reg.ack_number <= '0;
        end else if (cfg_wr_en) begin
            ctx_reg.send_seq   <= cfg_wr_data;
        end else if (advance) begin
            ctx_reg            <= ctx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.tx_kind;
    assign m_tdata  = {2'b00, res_reg.protocol_error, res_reg.event_res,
                       res_reg.conn_state, res_reg.tx_ack_num, res_reg.tx_seq};

endmodule

FILE: rtl/tcpc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpc_step
// Single-pass update of the connection context for one request: next phase,
// sequence and acknowledge numbers, and the result item.
// ----------------------------------------------------------------------------
module tcpc_step (
    input  tcpc_pkg::item_t   item,
    input  tcpc_pkg::ctx_t    ctx,
    output tcpc_pkg::ctx_t    ctx_next,
    output tcpc_pkg::result_t res
);

    tcpc_pkg::phase_t             phase_next;
    tcpc_pkg::tx_kind_t           kind;
    tcpc_pkg::event_t             ev;
    logic                         err;
    logic [tcpc_pkg::SEQ_W-1:0]   new_ack;
    logic [tcpc_pkg::SEQ_W-1:0]   seq_incr;
    logic                         len_nz;

    assign len_nz  = (item.length != '0);
    assign new_ack = item.rx_seq + (len_nz ?
                     {{(tcpc_pkg::SEQ_W-tcpc_pkg::LEN_W){1'b0}}, item.length} :
                     tcpc_pkg::SEQ_W'(1));

    // Next phase; unexpected segments fall through and hold the phase
    always_comb begin
        phase_next = ctx.phase;
        case (item.cmd)
            tcpc_pkg::CMD_CONNECT: phase_next = tcpc_pkg::PH_SYN_SENT;
            tcpc_pkg::CMD_CLOSE:   phase_next = tcpc_pkg::PH_FIN_WAIT1;
            tcpc_pkg::CMD_SEND:    phase_next = ctx.phase;
            tcpc_pkg::CMD_SEGMENT: begin
                case (ctx.phase)
                    tcpc_pkg::PH_SYN_SENT: begin
                        if (item.rx_syn && item.rx_ack) phase_next = tcpc_pkg::PH_ESTAB;
                    end
                    tcpc_pkg::PH_ESTAB: begin
                        if (!len_nz && item.rx_fin) phase_next = tcpc_pkg::PH_CLOSING;
                    end
                    tcpc_pkg::PH_FIN_WAIT1: begin
                        if (item.rx_ack && item.rx_fin) phase_next = tcpc_pkg::PH_CLOSED;
                        else if (item.rx_ack)           phase_next = tcpc_pkg::PH_FIN_WAIT2;
                        else if (item.rx_fin)           phase_next = tcpc_pkg::PH_CLOSING;
                    end
                    tcpc_pkg::PH_FIN_WAIT2: begin
                        if (item.rx_fin) phase_next = tcpc_pkg::PH_CLOSED;
                    end
                    tcpc_pkg::PH_CLOSING: begin
                        if (item.rx_ack) phase_next = tcpc_pkg::PH_CLOSED;
                    end
                    default: phase_next = ctx.phase;
                endcase
            end
            default: phase_next = ctx.phase;
        endcase
    end

    // Segment kind, event and error flag
    always_comb begin
        kind = tcpc_pkg::TX_NONE;
        ev   = tcpc_pkg::EV_NONE;
        err  = 1'b0;
        case (item.cmd)
            tcpc_pkg::CMD_CONNECT: kind = tcpc_pkg::TX_SYN;
            tcpc_pkg::CMD_CLOSE:   kind = tcpc_pkg::TX_FIN;
            tcpc_pkg::CMD_SEND:    kind = tcpc_pkg::TX_DATA;
            tcpc_pkg::CMD_SEGMENT: begin
                case (ctx.phase)
                    tcpc_pkg::PH_SYN_SENT: begin
                        if (item.rx_syn && item.rx_ack) begin
                            kind = tcpc_pkg::TX_ACK;
                            ev   = tcpc_pkg::EV_CONNECTED;
                        end else begin
                            err = 1'b1;
                        end
                    end
                    tcpc_pkg::PH_ESTAB: begin
                        // data wins over a FIN in the same segment
                        if (len_nz) begin
                            kind = tcpc_pkg::TX_ACK;
                            ev   = tcpc_pkg::EV_MESSAGE;
                        end else if (item.rx_fin) begin
                            kind = tcpc_pkg::TX_FINACK;
                        end else if (!item.rx_ack) begin
                            err = 1'b1;
                        end
                    end
                    tcpc_pkg::PH_FIN_WAIT1: begin
                        if (item.rx_ack && item.rx_fin) begin
                            kind = tcpc_pkg::TX_ACK;
                            ev   = tcpc_pkg::EV_CLOSED;
                        end else if (item.rx_ack) begin
                            kind = tcpc_pkg::TX_NONE;
                        end else if (item.rx_fin) begin
                            kind = tcpc_pkg::TX_ACK;
                        end else begin
                            err = 1'b1;
                        end
                    end
                    tcpc_pkg::PH_FIN_WAIT2: begin
                        if (item.rx_fin) begin
                            kind = tcpc_pkg::TX_ACK;
                            ev   = tcpc_pkg::EV_CLOSED;
                        end else begin
                            err = 1'b1;
                        end
                    end
                    tcpc_pkg::PH_CLOSING: begin
                        if (item.rx_ack) ev = tcpc_pkg::EV_CLOSED;
                        else             err = 1'b1;
                    end
                    default: kind = tcpc_pkg::TX_NONE;
                endcase
            end
            default: kind = tcpc_pkg::TX_NONE;
        endcase
    end

    // Sequence space used by this request
    always_comb begin
        case (item.cmd)
            tcpc_pkg::CMD_CONNECT: seq_incr = tcpc_pkg::SEQ_W'(1);
            tcpc_pkg::CMD_CLOSE:   seq_incr = tcpc_pkg::SEQ_W'(1);
            tcpc_pkg::CMD_SEND:
                seq_incr = {{(tcpc_pkg::SEQ_W-tcpc_pkg::LEN_W){1'b0}}, item.length};
            tcpc_pkg::CMD_SEGMENT:
                seq_incr = (kind == tcpc_pkg::TX_FINACK) ? tcpc_pkg::SEQ_W'(1) : '0;
            default: seq_incr = '0;
        endcase
    end

    always_comb begin
        ctx_next.phase      = phase_next;
        ctx_next.send_seq   = ctx.send_seq + seq_incr;
        ctx_next.ack_number = ctx.ack_number;
        res.tx_kind         = kind;
        res.conn_state      = phase_next;
        res.event_res       = ev;
        res.protocol_error  = err;
        res.tx_seq          = ctx.send_seq;
        res.tx_ack_num      = ctx.ack_number;
        case (item.cmd)
            tcpc_pkg::CMD_CONNECT: res.tx_ack_num = '0;
            tcpc_pkg::CMD_CLOSE:   res.tx_ack_num = ctx.ack_number;
            tcpc_pkg::CMD_SEND:    res.tx_ack_num = ctx.ack_number;
            tcpc_pkg::CMD_SEGMENT: begin
                if (!err) ctx_next.ack_number = new_ack;
                if (kind == tcpc_pkg::TX_NONE) begin
                    res.tx_seq     = '0;
                    res.tx_ack_num = '0;
                end else begin
                    res.tx_ack_num = new_ack;
                end
            end
            default: res.tx_ack_num = ctx.ack_number;
        endcase
    end

endmodule

FILE: verif/tcpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpc_checker
// Watches the request, result and configuration ports of the TCP client
// connection state machine. It keeps its own copy of the connection context,
// works out the segment each request should produce, and compares every
// result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tcpc_checker
    import tcpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [SEQ_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser,
    output int                   fail_count,
    output int                   pending
);

    phase_t           phase_now;
    logic [SEQ_W-1:0] next_seq;
    logic [SEQ_W-1:0] ack_val;
    result_t          expected_segments[$];
    int               mismatches;

    assign fail_count = mismatches;

    function automatic result_t advance_connection(item_t it);
        result_t          r;
        phase_t           nxt;
        logic [SEQ_W-1:0] new_ack;
        logic             err;
        tx_kind_t         kind;
        event_t           ev;
        r       = '0;
        nxt     = phase_now;
        err     = 1'b0;
        kind    = TX_NONE;
        ev      = EV_NONE;
        new_ack = it.rx_seq + ((it.length != '0) ? SEQ_W'(it.length) : SEQ_W'(1));
        case (it.cmd)
            CMD_CONNECT: begin
                kind      = TX_SYN;
                r.tx_seq  = next_seq;
                next_seq  = next_seq + 1;
                phase_now = PH_SYN_SENT;
            end
            CMD_CLOSE: begin
                kind         = TX_FIN;
                r.tx_seq     = next_seq;
                r.tx_ack_num = ack_val;
                next_seq     = next_seq + 1;
                phase_now    = PH_FIN_WAIT1;
            end
            CMD_SEND: begin
                kind         = TX_DATA;
                r.tx_seq     = next_seq;
                r.tx_ack_num = ack_val;
                next_seq     = next_seq + SEQ_W'(it.length);
            end
            default: begin
                case (phase_now)
                    PH_SYN_SENT: begin
                        if (it.rx_syn && it.rx_ack) begin
                            kind = TX_ACK;
                            nxt  = PH_ESTAB;
                            ev   = EV_CONNECTED;
                        end else begin
                            err = 1'b1;
                        end
                    end
                    PH_ESTAB: begin
                        // data takes precedence over FIN
                        if (it.length != '0) begin
                            kind = TX_ACK;
                            ev   = EV_MESSAGE;
                        end else if (it.rx_fin) begin
                            kind = TX_FINACK;
                            nxt  = PH_CLOSING;
                        end else if (!it.rx_ack) begin
                            err = 1'b1;
                        end
                    end
                    PH_FIN_WAIT1: begin
                        if (it.rx_ack && it.rx_fin) begin
                            kind = TX_ACK;
                            nxt  = PH_CLOSED;
                            ev   = EV_CLOSED;
                        end else if (it.rx_ack) begin
                            nxt = PH_FIN_WAIT2;
                        end else if (it.rx_fin) begin
                            kind = TX_ACK;
                            nxt  = PH_CLOSING;
                        end else begin
                            err = 1'b1;
                        end
                    end
                    PH_FIN_WAIT2: begin
                        if (it.rx_fin) begin
                            kind = TX_ACK;
                            nxt  = PH_CLOSED;
                            ev   = EV_CLOSED;
                        end else begin
                            err = 1'b1;
                        end
                    end
                    PH_CLOSING: begin
                        if (it.rx_ack) begin
                            nxt = PH_CLOSED;
                            ev  = EV_CLOSED;
                        end else begin
                            err = 1'b1;
                        end
                    end
                    default: ;
                endcase
                // an unexpected segment leaves the whole context alone
                if (err) begin
                    kind = TX_NONE;
                    ev   = EV_NONE;
                end else begin
                    ack_val   = new_ack;
                    phase_now = nxt;
                    if (kind != TX_NONE) begin
                        r.tx_seq     = next_seq;
                        r.tx_ack_num = ack_val;
                        if (kind == TX_FINACK) begin
                            next_seq = next_seq + 1;
                        end
                    end
                end
            end
        endcase
        r.tx_kind        = kind;
        r.conn_state     = phase_now;
        r.event_res      = ev;
        r.protocol_error = err;
        return r;
    endfunction

    always @(posedge aclk) begin
        item_t   req;
        result_t act;
        result_t exp;
        if (!aresetn) begin
            phase_now = PH_CLOSED;
            next_seq  = '0;
            ack_val   = '0;
            expected_segments.delete();
        end else begin
            if (cfg_wr_en) begin
                next_seq = cfg_wr_data;
            end
            // compare before queuing, so a stray result never meets a new prediction
            if (m_tvalid && m_tready) begin
                act.tx_kind        = tx_kind_t'(m_tuser[2:0]);
                act.tx_seq         = m_tdata[31:0];
                act.tx_ack_num     = m_tdata[63:32];
                act.conn_state     = phase_t'(m_tdata[66:64]);
                act.event_res      = event_t'(m_tdata[68:67]);
                act.protocol_error = m_tdata[69];
                if (expected_segments.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("[%0t] result with no request outstanding: kind %0d seq %h",
                                 $realtime, act.tx_kind, act.tx_seq);
                    end
                end else begin
                    exp = expected_segments.pop_front();
                    if (act !== exp) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("[%0t] result mismatch (expected / actual):", $realtime);
                            $display("  kind %0d / %0d  seq %h / %h  ack %h / %h",
                                     exp.tx_kind, act.tx_kind, exp.tx_seq, act.tx_seq,
                                     exp.tx_ack_num, act.tx_ack_num);
                            $display("  state %0d / %0d  event %0d / %0d  error %0d / %0d",
                                     exp.conn_state, act.conn_state, exp.event_res,
                                     act.event_res, exp.protocol_error, act.protocol_error);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                req.cmd    = cmd_t'(s_tuser[1:0]);
                req.rx_seq = s_tdata[31:0];
                req.length = s_tdata[47:32];
                req.rx_syn = s_tdata[48];
                req.rx_ack = s_tdata[49];
                req.rx_fin = s_tdata[50];
                expected_segments.push_back(advance_connection(req));
            end
        end
        pending <= expected_segments.size();
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the TCP client connection state machine with a directed opening,
// then random connection sessions (well formed, broken and pure noise)
// under three idling patterns and several initial sequence numbers. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import tcpc_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [SEQ_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    int                   fail_count;
    int                   pending;

    int send_idle;
    int recv_idle;
    int hold_ready_cycles;
    int requests_sent;

    tcp_client_connection_fsm dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    tcpc_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("testbench NOT OK");
        $finish;
    end

    // result side: random back-pressure, plus long hold-offs on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_ready_cycles > 0) begin
                m_tready <= 1'b0;
                hold_ready_cycles--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    function automatic item_t make_req(cmd_t c, logic [SEQ_W-1:0] sq, logic [LEN_W-1:0] len,
                                       logic syn, logic ack, logic fin);
        item_t it;
        it.cmd    = c;
        it.rx_seq = sq;
        it.length = len;
        it.rx_syn = syn;
        it.rx_ack = ack;
        it.rx_fin = fin;
        return it;
    endfunction

    function automatic item_t noise_req();
        return make_req(cmd_t'(2'($urandom_range(3))), $urandom,
                        LEN_W'($urandom_range(65535)), 1'($urandom_range(1)),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
    endfunction

    // mostly short payloads, now and then a large one or the maximum
    function automatic logic [LEN_W-1:0] pick_length(bit allow_zero);
        int r;
        r = $urandom_range(9);
        if (r == 0 && allow_zero) begin
            return '0;
        end else if (r < 7) begin
            return LEN_W'($urandom_range(1, 64));
        end else if (r < 9) begin
            return LEN_W'($urandom_range(1, 65535));
        end
        return '1;
    endfunction

    task automatic push_request(item_t it);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, it.rx_fin, it.rx_ack, it.rx_syn, it.length, it.rx_seq};
        s_tuser  <= it.cmd;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    // occasionally drop a step or swap it for noise to break the session
    task automatic offer(item_t it);
        int r;
        r = $urandom_range(99);
        if (r < 4) begin
            return;
        end else if (r < 7) begin
            push_request(noise_req());
        end else begin
            push_request(it);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_initial_seq(logic [SEQ_W-1:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_session();
        int n;
        n = $urandom_range(6);
        offer(make_req(CMD_CONNECT, $urandom, LEN_W'($urandom), 1'($urandom_range(1)),
                       1'($urandom_range(1)), 1'($urandom_range(1))));
        offer(make_req(CMD_SEGMENT, $urandom, pick_length(1), 1'b1, 1'b1,
                       1'($urandom_range(1))));
        repeat (n) begin
            case ($urandom_range(2))
                0: offer(make_req(CMD_SEND, $urandom, pick_length(1), 1'($urandom_range(1)),
                                  1'($urandom_range(1)), 1'($urandom_range(1))));
                1: offer(make_req(CMD_SEGMENT, $urandom, pick_length(0), 1'b0, 1'b1,
                                  1'($urandom_range(1))));
                default: offer(make_req(CMD_SEGMENT, $urandom, '0, 1'b0, 1'b1, 1'b0));
            endcase
        end
        case ($urandom_range(3))
            0: begin
                offer(make_req(CMD_CLOSE, $urandom, LEN_W'($urandom), 1'b0, 1'b0, 1'b0));
                offer(make_req(CMD_SEGMENT, $urandom, '0, 1'b0, 1'b1, 1'b0));
                offer(make_req(CMD_SEGMENT, $urandom, pick_length(1), 1'b0,
                               1'($urandom_range(1)), 1'b1));
            end
            1: begin
                offer(make_req(CMD_CLOSE, $urandom, LEN_W'($urandom), 1'b0, 1'b0, 1'b0));
                offer(make_req(CMD_SEGMENT, $urandom, pick_length(1), 1'b0, 1'b1, 1'b1));
            end
            2: begin
                offer(make_req(CMD_CLOSE, $urandom, LEN_W'($urandom), 1'b0, 1'b0, 1'b0));
                offer(make_req(CMD_SEGMENT, $urandom, pick_length(1), 1'b0, 1'b0, 1'b1));
                offer(make_req(CMD_SEGMENT, $urandom, pick_length(1), 1'b0, 1'b1, 1'b0));
            end
            default: begin
                // peer closes first
                offer(make_req(CMD_SEGMENT, $urandom, '0, 1'b0, 1'($urandom_range(1)), 1'b1));
                offer(make_req(CMD_SEGMENT, $urandom, pick_length(1), 1'b0, 1'b1,
                               1'($urandom_range(1))));
            end
        endcase
    endtask

    task automatic run_phase(int target, int s_idle, int r_idle, int stall, bit mid_pause);
        int goal;
        int mid;
        bit paused;
        send_idle = s_idle;
        recv_idle = r_idle;
        goal      = requests_sent + target;
        mid       = requests_sent + target / 2;
        paused    = 1'b0;
        // the sender keeps offering while the result side is held off
        if (stall > 0) begin
            hold_ready_cycles = stall;
        end
        while (requests_sent < goal) begin
            if (mid_pause && !paused && requests_sent >= mid) begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(9) < 8) begin
                run_session();
            end else begin
                repeat ($urandom_range(1, 3)) push_request(noise_req());
            end
        end
    endtask

    task automatic run_directed();
        push_request(make_req(CMD_SEGMENT, '1, '0, 1'b1, 1'b1, 1'b1));
        push_request(make_req(CMD_CONNECT, '0, '0, 1'b0, 1'b0, 1'b0));
        push_request(make_req(CMD_SEGMENT, 32'h1234_5678, '0, 1'b1, 1'b0, 1'b0));
        push_request(make_req(CMD_SEGMENT, '1, '0, 1'b1, 1'b1, 1'b0));
        push_request(make_req(CMD_SEND, '1, '0, 1'b1, 1'b1, 1'b1));
        push_request(make_req(CMD_SEND, '0, '1, 1'b0, 1'b0, 1'b0));
        push_request(make_req(CMD_SEGMENT, '1, '1, 1'b0, 1'b1, 1'b0));
        push_request(make_req(CMD_SEGMENT, 32'h8000_0000, 16'd5, 1'b0, 1'b1, 1'b1));
        push_request(make_req(CMD_SEGMENT, 32'h0000_0100, '0, 1'b0, 1'b1, 1'b0));
        push_request(make_req(CMD_SEGMENT, 32'h0000_0200, '0, 1'b0, 1'b0, 1'b0));
        push_request(make_req(CMD_SEGMENT, 32'h0000_0300, '0, 1'b0, 1'b0, 1'b1));
        push_request(make_req(CMD_SEGMENT, 32'h0000_0400, '0, 1'b1, 1'b0, 1'b1));
        push_request(make_req(CMD_SEGMENT, 32'h0000_0500, 16'h8000, 1'b0, 1'b1, 1'b0));
        push_request(make_req(CMD_CLOSE, '1, '1, 1'b1, 1'b1, 1'b1));
        push_request(make_req(CMD_SEGMENT, 32'h0000_0600, '0, 1'b1, 1'b0, 1'b0));
        push_request(make_req(CMD_SEGMENT, 32'h0000_0700, '0, 1'b0, 1'b1, 1'b0));
        push_request(make_req(CMD_SEGMENT, 32'h0000_0800, '0, 1'b0, 1'b1, 1'b0));
        push_request(make_req(CMD_SEGMENT, 32'hFFFF_FFFE, '0, 1'b0, 1'b0, 1'b1));
        push_request(make_req(CMD_CLOSE, '0, '0, 1'b0, 1'b0, 1'b0));
        push_request(make_req(CMD_SEGMENT, 32'h0000_0900, 16'd3, 1'b0, 1'b1, 1'b1));
        push_request(make_req(CMD_CLOSE, '0, '0, 1'b0, 1'b0, 1'b0));
        push_request(make_req(CMD_SEGMENT, 32'h0000_0A00, '0, 1'b0, 1'b0, 1'b1));
        push_request(make_req(CMD_SEGMENT, 32'h0000_0B00, '0, 1'b0, 1'b1, 1'b0));
        push_request(make_req(CMD_CONNECT, '1, '1, 1'b1, 1'b1, 1'b1));
        push_request(make_req(CMD_CLOSE, '0, '0, 1'b0, 1'b0, 1'b0));
    endtask

    initial begin
        aresetn           = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        s_tvalid          = 1'b0;
        s_tdata           = '0;
        s_tuser           = '0;
        send_idle         = 0;
        recv_idle         = 0;
        hold_ready_cycles = 0;
        requests_sent     = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // seed near the top so the sequence wraps early
        write_initial_seq(32'hFFFF_FFFE);
        send_idle = 23;
        recv_idle = 72;
        run_directed();

        write_initial_seq('0);
        run_phase(210, 23, 72, 120, 1'b0);

        write_initial_seq('1);
        run_phase(210, 72, 23, 0, 1'b0);

        write_initial_seq($urandom);
        run_phase(210, 0, 0, 150, 1'b1);

        drain();
        repeat (4) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
